/* sv/fsn_pkg.sv */
// fsn_pkg: constants and the byte clean-up function for the short name encoder
// no dependencies; imported by fat_short_name_encoder
package fsn_pkg;

  // sizes of the short name fields
  localparam int unsigned BASE_KEEP = 8;
  localparam int unsigned EXT_KEEP  = 3;
  localparam int unsigned BASE_LEN_W = 4;
  localparam int unsigned EXT_LEN_W  = 2;
  localparam logic [BASE_LEN_W-1:0] BASE_SAT = 4'd9;
  localparam logic [BASE_LEN_W-1:0] BASE_MAX = 4'd8;
  localparam logic [EXT_LEN_W-1:0]  EXT_MAX  = 2'd3;

  // byte codes
  localparam logic [7:0] PAD_BYTE      = 8'd32;
  localparam logic [7:0] TOP_PRINTABLE = 8'd126;
  localparam logic [7:0] DOT_BYTE      = 8'd46;
  localparam logic [7:0] FILL_BYTE     = 8'd95;
  localparam logic [7:0] TILDE_BYTE    = 8'd126;
  localparam logic [7:0] ONE_BYTE      = 8'd49;
  localparam logic [7:0] LOWER_A       = 8'd97;
  localparam logic [7:0] LOWER_Z       = 8'd122;
  localparam logic [7:0] CASE_OFFSET   = 8'd32;

  // fold lowercase to uppercase, replace space, control and high bytes
  function automatic logic [7:0] clean_byte(input logic [7:0] c);
    logic [7:0] r;
    if (c >= LOWER_A && c <= LOWER_Z) begin
      r = c - CASE_OFFSET;
    end else if (c <= PAD_BYTE || c > TOP_PRINTABLE) begin
      r = FILL_BYTE;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

/* sv/fat_short_name_encoder.sv */
// fat_short_name_encoder: builds an 8.3 short name from a byte stream
// depends on fsn_pkg
//
// Bytes of a file name arrive one per beat on the slave side; a beat with
// tlast set ends the name (its data byte is ignored) and produces one beat
// on the master side holding the space padded 8-byte base and 3-byte
// extension. Dots switch to the extension and are dropped, lowercase is
// folded to uppercase, and space, control and bytes above 126 become '_'.
// A base longer than eight bytes is cut to six followed by "~1". Every beat
// passes an input register, then clean-up and store logic into the name
// registers or the result register, so a byte is taken in every cycle
// except while the input side stalls. The input
// side only stalls while a finished result waits on the master side and
// another end beat is ready to be turned into a result.
module fat_short_name_encoder
  import fsn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tlast,   // end_of_name
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata    // [63:0] base_field, [87:64] extension_field
);

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // name state
  logic [7:0]            base_store [BASE_KEEP];
  logic [BASE_LEN_W-1:0] base_length;
  logic [7:0]            ext_store [EXT_KEEP];
  logic [EXT_LEN_W-1:0]  ext_length;
  logic                  ext_mode;

  // result register
  logic        out_valid;
  logic [63:0] out_base;
  logic [23:0] out_ext;

  logic        advance;
  logic [7:0]  clean_char;
  logic [63:0] base_next;
  logic [23:0] ext_next;

  // an end beat needs room in the result register
  assign advance       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign clean_char    = clean_byte(in_char);

  // capture input beats
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // assemble padded fields from the stored name
  always_comb begin
    for (int i = 0; i < BASE_KEEP; i++) begin
      if (BASE_LEN_W'(i) < base_length) begin
        base_next[63 - 8*i -: 8] = base_store[i];
      end else begin
        base_next[63 - 8*i -: 8] = PAD_BYTE;
      end
    end
    if (base_length > BASE_MAX) begin
      base_next[15:8] = TILDE_BYTE;
      base_next[7:0]  = ONE_BYTE;
    end
    for (int j = 0; j < EXT_KEEP; j++) begin
      if (EXT_LEN_W'(j) < ext_length) begin
        ext_next[23 - 8*j -: 8] = ext_store[j];
      end else begin
        ext_next[23 - 8*j -: 8] = PAD_BYTE;
      end
    end
  end

  // name state update
  always_ff @(posedge clk) begin
    if (rst) begin
      base_length <= '0;
      ext_length  <= '0;
      ext_mode    <= 1'b0;
      for (int i = 0; i < BASE_KEEP; i++) begin
        base_store[i] <= '0;
      end
      for (int j = 0; j < EXT_KEEP; j++) begin
        ext_store[j] <= '0;
      end
    end else if (advance) begin
      if (in_last) begin
        base_length <= '0;
        ext_length  <= '0;
        ext_mode    <= 1'b0;
        for (int i = 0; i < BASE_KEEP; i++) begin
          base_store[i] <= '0;
        end
        for (int j = 0; j < EXT_KEEP; j++) begin
          ext_store[j] <= '0;
        end
      end else if (in_char == DOT_BYTE) begin
        ext_mode <= 1'b1;
      end else if (!ext_mode) begin
        if (base_length < BASE_MAX) begin
          base_store[base_length[2:0]] <= clean_char;
        end
        if (base_length < BASE_SAT) begin
          base_length <= base_length + 1'b1;
        end
      end else if (ext_length < EXT_MAX) begin
        ext_store[ext_length] <= clean_char;
        ext_length <= ext_length + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && in_last) begin
      out_base <= base_next;
      out_ext  <= ext_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_ext, out_base};

`ifndef ASSERT_OFF
  // base length counter stays in range
  a_base_len: assert property (@(posedge clk) disable iff (rst)
    base_length <= BASE_SAT)
    else $error("base length beyond saturation");

  // state is cleared once a name is finished
  a_clear: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> base_length == '0 && ext_length == '0 && !ext_mode)
    else $error("name state not cleared after end beat");

  // a result only appears after an end beat was taken
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && in_last))
    else $error("result without end beat");

  // a waiting result is never overwritten
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |-> !(advance && in_last))
    else $error("pending result overwritten");
`endif

endmodule
